### rtl/core/afct_pkg.sv
// shared types and constants for the aabb frustum cull test unit
`default_nettype none

package afct_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int PLANE_COUNT      = 6;
  localparam int FIELD_WIDTH      = 16;
  localparam int CFG_DATA_WIDTH   = 4 * FIELD_WIDTH;
  localparam int CFG_INDEX_WIDTH  = 3;

  localparam int PROD_WIDTH = COORD_WIDTH + FIELD_WIDTH;
  localparam int DIST_WIDTH = FIELD_WIDTH + NORMAL_FRAC_BITS;
  localparam int ACC_WIDTH  = ((PROD_WIDTH > DIST_WIDTH) ? PROD_WIDTH : DIST_WIDTH) + 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_LEFT   = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_RIGHT  = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_BOTTOM = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_TOP    = CFG_INDEX_WIDTH'(3);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_NEAR   = CFG_INDEX_WIDTH'(4);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_FAR    = CFG_INDEX_WIDTH'(5);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_min_z;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_max_z;
  } box_t;

  typedef struct packed {
    logic visible;
    logic box_empty;
  } result_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] offset;
    logic signed [FIELD_WIDTH-1:0] nz;
    logic signed [FIELD_WIDTH-1:0] ny;
    logic signed [FIELD_WIDTH-1:0] nx;
  } plane_t;

  // one box moving down the row of plane cells
  typedef struct packed {
    logic    valid;
    box_t    box;
    logic    visible;
    logic    empty;
  } token_t;

endpackage

`default_nettype wire

### rtl/core/aabb_frustum_cull_test_unit.sv
// aabb frustum cull test top level: input register and a row of six plane cells
// result strobed on done once the accepted box has passed the input register and the stages of all six plane cells
// throughput: one box per cycle, busy stays low; each plane cell has two stages
// the receiver cannot stall, so nothing ever holds the row of cells
// reset: synchronous; clears the pipeline valid bits and all six planes to zero
`default_nettype none

module aabb_frustum_cull_test_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire afct_pkg::box_t                        box,
  output logic                                       done,
  output afct_pkg::result_t                          result,
  input  wire logic                                  cfg_we,
  input  wire logic [afct_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [afct_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import afct_pkg::*;

  token_t                 tok [0:PLANE_COUNT];
  token_t                 tok_head;
  logic [PLANE_COUNT-1:0] plane_we;
  logic                   box_empty_in;

  assign busy = 1'b0;

  assign box_empty_in = (box.box_min_x > box.box_max_x) |
                        (box.box_min_y > box.box_max_y) |
                        (box.box_min_z > box.box_max_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_head.valid <= 1'b0;
    end else begin
      tok_head.valid <= start & ~busy;
    end
    tok_head.box     <= box;
    tok_head.visible <= 1'b1;
    tok_head.empty   <= box_empty_in;
  end

  assign tok[0] = tok_head;

  always_comb begin
    plane_we = '0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PLANE_LEFT:   plane_we[0] = 1'b1;
        REG_PLANE_RIGHT:  plane_we[1] = 1'b1;
        REG_PLANE_BOTTOM: plane_we[2] = 1'b1;
        REG_PLANE_TOP:    plane_we[3] = 1'b1;
        REG_PLANE_NEAR:   plane_we[4] = 1'b1;
        REG_PLANE_FAR:    plane_we[5] = 1'b1;
        default:          plane_we    = '0;
      endcase
    end
  end

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    afct_plane_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .plane_we   (plane_we[i]),
      .plane_data (plane_t'(cfg_data)),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  assign done             = tok[PLANE_COUNT].valid;
  assign result.visible   = tok[PLANE_COUNT].visible;
  assign result.box_empty = tok[PLANE_COUNT].empty;

  // a result only follows an accepted transaction
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 13))
    else $error("result without an accepted transaction");

  // emptiness flag travels unchanged through the row
  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.box_empty == $past(box_empty_in, 13)))
    else $error("box_empty does not match the accepted box");

  // an empty box is never culled
  assert property (@(posedge clk) disable iff (rst)
    (done && result.box_empty) |-> result.visible)
    else $error("empty box culled");

endmodule

`default_nettype wire

### rtl/core/afct_plane_cell.sv
// one plane test cell: corner select and products, then sum and sign
`default_nettype none

module afct_plane_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              plane_we,
  input  wire afct_pkg::plane_t  plane_data,
  input  wire afct_pkg::token_t  tok_in,
  output afct_pkg::token_t       tok_out
);
  import afct_pkg::*;

  plane_t plane;

  logic signed [COORD_WIDTH-1:0] px, py, pz;
  logic signed [PROD_WIDTH-1:0]  prod_x_next, prod_y_next, prod_z_next;
  logic signed [PROD_WIDTH-1:0]  prod_x, prod_y, prod_z;
  logic signed [ACC_WIDTH-1:0]   dist_sh;
  logic signed [ACC_WIDTH-1:0]   acc;
  token_t                        tok_a;
  token_t                        tok_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (plane_we) begin
      plane <= plane_data;
    end
  end

  // farthest corner along the normal
  assign px = (plane.nx >= 0) ? tok_in.box.box_max_x : tok_in.box.box_min_x;
  assign py = (plane.ny >= 0) ? tok_in.box.box_max_y : tok_in.box.box_min_y;
  assign pz = (plane.nz >= 0) ? tok_in.box.box_max_z : tok_in.box.box_min_z;

  assign prod_x_next = plane.nx * px;
  assign prod_y_next = plane.ny * py;
  assign prod_z_next = plane.nz * pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_a.valid <= 1'b0;
    end else begin
      tok_a.valid <= tok_in.valid;
    end
    tok_a.box     <= tok_in.box;
    tok_a.visible <= tok_in.visible;
    tok_a.empty   <= tok_in.empty;
    prod_x        <= prod_x_next;
    prod_y        <= prod_y_next;
    prod_z        <= prod_z_next;
    dist_sh       <= ACC_WIDTH'(plane.offset) <<< NORMAL_FRAC_BITS;
  end

  assign acc = ACC_WIDTH'(prod_x) + ACC_WIDTH'(prod_y) + ACC_WIDTH'(prod_z) + dist_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_b.valid <= 1'b0;
    end else begin
      tok_b.valid <= tok_a.valid;
    end
    tok_b.box     <= tok_a.box;
    tok_b.visible <= tok_a.visible & (tok_a.empty | ~acc[ACC_WIDTH-1]);
    tok_b.empty   <= tok_a.empty;
  end

  assign tok_out = tok_b;

endmodule

`default_nettype wire
